// ===== rtl/brbs_pkg.sv =====
// Shared types and codes for the byte ring buffer with pattern search.
// Holds the input and result beat structs, the action codes and the
// configuration register indexes. No dependencies.
`default_nettype none

package brbs_pkg;

    // Action codes carried in the input beat
    localparam logic [1:0] ACT_PUT   = 2'd0;
    localparam logic [1:0] ACT_GET   = 2'd1;
    localparam logic [1:0] ACT_FIND  = 2'd2;
    localparam logic [1:0] ACT_CLEAR = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERWRITE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN   = 2'd2;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic       done_ok;
        logic       dropped_oldest;
        logic [7:0] read_byte;
        logic [9:0] match_offset;
        logic [9:0] fill_level;
    } t_out_item;

endpackage

`default_nettype wire

// ===== rtl/byte_ring_buffer_with_search_top.sv =====
// Top level of the byte ring buffer with pattern search.
// Holds the byte store, the action sequencer, the streaming pattern compare
// and the result register with its skid stage. Depends on brbs_pkg.
`default_nettype none

// A circular store of DEPTH bytes driven by one action per input beat: put,
// get, find or clear. Every beat yields exactly one result beat carrying the
// status, the dropped flag, the byte read, the match offset and the fill level
// after the action. Put, clear, get on an empty buffer and find with fewer
// bytes held than the pattern length are answered at once from S_IDLE. Get
// with data waits in S_GET for the registered read port of the byte store.
// Find scans the held bytes oldest first, one store read per cycle, through
// a window of the last MAX_PATTERN bytes and one shared compare. A hit ends
// the scan with its start offset, a miss once the last held byte has reached
// the window. The input stalls while a get or a find is running
// or while the result skid stage is occupied; a finished result may wait in
// the output register while the next beat is taken. The store needs no
// clearing pass after reset: only bytes that were put are ever read. The
// configuration port is always ready and is meant to be written while the
// block is idle; writes to an index beyond the register list are ignored.
module byte_ring_buffer_with_search_top
    import brbs_pkg::*;
#(
    parameter int unsigned DEPTH       = 512,
    parameter int unsigned MAX_PATTERN = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // input beats
    input  wire logic                 i_in_valid,
    output      logic                 o_in_stall,
    input  wire t_in_item             i_in_item,
    // result beats
    output      logic                 o_out_valid,
    input  wire logic                 i_out_stall,
    output      t_out_item            o_out_item,
    // configuration writes
    input  wire logic                 i_cfg_valid,
    output      logic                 o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [63:0]          i_cfg_data
);

    localparam int unsigned IW     = $clog2(DEPTH);        // store index width
    localparam int unsigned CW     = $clog2(DEPTH + 1);    // fill count width
    localparam int unsigned CMPW   = (CW > 4) ? CW : 4;    // count vs length compare
    localparam int unsigned WIN_IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_GET,
        S_SCAN
    } t_state;

    function automatic logic [IW-1:0] advance(input logic [IW-1:0] idx);
        advance = (idx == IW'(DEPTH - 1)) ? '0 : idx + IW'(1);
    endfunction

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic        r_ovw;
    logic [63:0] r_pat;
    logic [3:0]  r_plen;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovw  <= 1'b0;
            r_pat  <= '0;
            r_plen <= 4'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_OVERWRITE: r_ovw  <= i_cfg_data[0];
                CFG_PATTERN:   r_pat  <= i_cfg_data;
                CFG_PAT_LEN:   r_plen <= i_cfg_data[3:0];
                default:       ;
            endcase
        end
    end

    // Length 0 acts as 1, lengths past MAX_PATTERN saturate
    logic [3:0] len_eff;
    always_comb begin
        if (r_plen == 4'd0) begin
            len_eff = 4'd1;
        end else if (r_plen > 4'(MAX_PATTERN)) begin
            len_eff = 4'(MAX_PATTERN);
        end else begin
            len_eff = r_plen;
        end
    end

    // ---------------------------------------------------------------
    // Byte store: one write port, one registered read port
    // ---------------------------------------------------------------
    logic [7:0]    mem [DEPTH];
    logic          mem_we;
    logic [IW-1:0] mem_wa;
    logic [7:0]    mem_wd;
    logic [IW-1:0] rd_addr;
    logic [7:0]    r_rdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rdata <= mem[rd_addr];
    end

    // ---------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------
    t_state        r_state,  n_state;
    logic [IW-1:0] r_wr_idx, n_wr_idx;
    logic [IW-1:0] r_rd_idx, n_rd_idx;
    logic [CW-1:0] r_count,  n_count;

    // find scan: address issue, read data tag, window tag
    logic [IW-1:0] r_saddr,  n_saddr;
    logic [CW-1:0] r_ik,     n_ik;      // bytes issued so far
    logic          r_dv,     n_dv;      // r_rdata holds a scanned byte
    logic [IW-1:0] r_dk,     n_dk;      // its offset from the oldest byte
    logic          r_wv,     n_wv;      // window just took a byte
    logic [IW-1:0] r_wk,     n_wk;      // offset of the newest window byte
    logic [3:0]    r_len,    n_len;

    // result register and skid stage
    logic          r_ov,     n_ov;
    t_out_item     r_out,    n_out;
    logic          r_sv,     n_sv;
    t_out_item     r_skid,   n_skid;

    logic          in_acc;
    logic          out_take;
    logic          res_valid;
    t_out_item     res;

    // window of the last MAX_PATTERN scanned bytes, entry 0 newest
    logic [7:0]    r_win [MAX_PATTERN];
    logic          win_hit;
    logic [3:0]    win_pos;
    logic          win_ready;
    logic          win_last;
    logic [CMPW-1:0] win_off;

    assign o_in_stall  = !((r_state == S_IDLE) && !r_sv);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_take    = r_ov && !i_out_stall;
    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (r_dv) begin
            r_win[0] <= r_rdata;
            for (int j = 1; j < MAX_PATTERN; j++) begin
                r_win[j] <= r_win[j-1];
            end
        end
    end

    // Shared compare: pattern byte j against the byte j places after the start
    always_comb begin
        win_hit = 1'b1;
        win_pos = '0;
        for (int j = 0; j < MAX_PATTERN; j++) begin
            if (4'(j) < r_len) begin
                win_pos = r_len - 4'(j) - 4'd1;
                if (r_win[win_pos[WIN_IW-1:0]] != r_pat[8*j +: 8]) begin
                    win_hit = 1'b0;
                end
            end
        end
    end

    assign win_ready = CMPW'(r_wk) >= (CMPW'(r_len) - CMPW'(1));
    assign win_last  = (CW'(r_wk) + CW'(1)) == r_count;
    assign win_off   = CMPW'(r_wk) - CMPW'(r_len) + CMPW'(1);

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb begin
        n_state  = r_state;
        n_wr_idx = r_wr_idx;
        n_rd_idx = r_rd_idx;
        n_count  = r_count;
        n_saddr  = r_saddr;
        n_ik     = r_ik;
        n_dv     = r_dv;
        n_dk     = r_dk;
        n_wv     = r_wv;
        n_wk     = r_wk;
        n_len    = r_len;
        mem_we   = 1'b0;
        mem_wa   = r_wr_idx;
        mem_wd   = i_in_item.data_byte;
        rd_addr  = (r_state == S_SCAN) ? r_saddr : r_rd_idx;
        res_valid = 1'b0;
        res       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in_item.action)
                        ACT_PUT: begin
                            res_valid = 1'b1;
                            if (r_count < CW'(DEPTH)) begin
                                mem_we       = 1'b1;
                                n_wr_idx     = advance(r_wr_idx);
                                n_count      = r_count + CW'(1);
                                res.done_ok  = 1'b1;
                            end else if (r_ovw) begin
                                // full: oldest byte gives way
                                mem_we             = 1'b1;
                                n_wr_idx           = advance(r_wr_idx);
                                n_rd_idx           = advance(r_rd_idx);
                                res.done_ok        = 1'b1;
                                res.dropped_oldest = 1'b1;
                            end
                            res.fill_level = 10'(n_count);
                        end
                        ACT_GET: begin
                            if (r_count != '0) begin
                                // read of r_rd_idx is issued this cycle
                                n_rd_idx = advance(r_rd_idx);
                                n_count  = r_count - CW'(1);
                                n_state  = S_GET;
                            end else begin
                                res_valid      = 1'b1;
                                res.fill_level = 10'(r_count);
                            end
                        end
                        ACT_FIND: begin
                            n_len = len_eff;
                            if (CMPW'(r_count) < CMPW'(len_eff)) begin
                                res_valid      = 1'b1;
                                res.fill_level = 10'(r_count);
                            end else begin
                                n_state = S_SCAN;
                                n_saddr = r_rd_idx;
                                n_ik    = '0;
                                n_dv    = 1'b0;
                                n_wv    = 1'b0;
                            end
                        end
                        ACT_CLEAR: begin
                            n_wr_idx    = '0;
                            n_rd_idx    = '0;
                            n_count     = '0;
                            res_valid   = 1'b1;
                            res.done_ok = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_GET: begin
                res_valid      = 1'b1;
                res.done_ok    = 1'b1;
                res.read_byte  = r_rdata;
                res.fill_level = 10'(r_count);
                n_state        = S_IDLE;
            end
            S_SCAN: begin
                if (r_ik < r_count) begin
                    n_saddr = advance(r_saddr);
                    n_ik    = r_ik + CW'(1);
                    n_dv    = 1'b1;
                    n_dk    = r_ik[IW-1:0];
                end else begin
                    n_dv    = 1'b0;
                end
                n_wv = r_dv;
                n_wk = r_dk;
                if (r_wv && win_ready && win_hit) begin
                    res_valid        = 1'b1;
                    res.done_ok      = 1'b1;
                    res.match_offset = 10'(win_off);
                    res.fill_level   = 10'(r_count);
                    n_state          = S_IDLE;
                end else if (r_wv && win_last) begin
                    res_valid      = 1'b1;
                    res.fill_level = 10'(r_count);
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // result register with skid stage, order kept
        n_ov   = r_ov;
        n_out  = r_out;
        n_sv   = r_sv;
        n_skid = r_skid;
        if (out_take || !r_ov) begin
            if (r_sv) begin
                n_out  = r_skid;
                n_ov   = 1'b1;
                n_skid = res;
                n_sv   = res_valid;
            end else begin
                n_out  = res;
                n_ov   = res_valid;
            end
        end else if (res_valid) begin
            n_skid = res;
            n_sv   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out   <= n_out;
        r_skid  <= n_skid;
        r_saddr <= n_saddr;
        r_dk    <= n_dk;
        r_wk    <= n_wk;
        r_len   <= n_len;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wr_idx <= '0;
            r_rd_idx <= '0;
            r_count  <= '0;
            r_ik     <= '0;
            r_dv     <= 1'b0;
            r_wv     <= 1'b0;
            r_ov     <= 1'b0;
            r_sv     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wr_idx <= n_wr_idx;
            r_rd_idx <= n_rd_idx;
            r_count  <= n_count;
            r_ik     <= n_ik;
            r_dv     <= n_dv;
            r_wv     <= n_wv;
            r_ov     <= n_ov;
            r_sv     <= n_sv;
        end
    end

`ifndef SYNTHESIS
    // skid holds a beat only behind a waiting result beat
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid stage valid while output register empty");

    // fill count never passes the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count above depth");

    // a get with data is answered from the store on the next cycle
    a_get_to_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in_item.action == ACT_GET) && (r_count != '0))
        |=> (r_state == S_GET))
        else $error("get with data did not enter read cycle");

    // scan never issues past the held bytes
    a_scan_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_ik <= r_count))
        else $error("scan issued beyond fill level");
`endif

endmodule

`default_nettype wire
